FILE: hdl/lru_writeback_cache_set_assert.svh
// Assertion macros shared by the RTL of the cache set.
// Each macro takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef LRU_WRITEBACK_CACHE_SET_ASSERT_SVH
`define LRU_WRITEBACK_CACHE_SET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWCS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lwcs_pkg.sv
`timescale 1ns / 1ps

package lwcs_pkg;

    localparam int WAYS     = 4;
    localparam int TAG_BITS = 24;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam int TAG_FIELD_W = 24;
    localparam int WAY_FIELD_W = 2;
    localparam int CNT_W       = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic                   action;
        logic [TAG_FIELD_W-1:0] tag;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] way;
        logic                   writeback;
        logic [TAG_FIELD_W-1:0] victim_tag;
        logic [CNT_W-1:0]       hit_count;
        logic [CNT_W-1:0]       miss_count;
        logic [CNT_W-1:0]       writeback_count;
    } t_out_item;

    typedef struct packed {
        logic in_stall;
        logic scan_en;
        logic upd_en;
    } t_ctl;

    localparam logic       ACT_WRITE = 1'b1;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

FILE: hdl/lru_writeback_cache_set.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_item (t_out_item)
//
// An item passes three steps: it is accepted, each way in turn goes through the single tag
// comparator while the least recent way is tracked, and the set state is updated.
// The block takes no new item until the current one has been written to the output register.
// A stalled output holds the update step, so the item then waits until the register frees.
// Reset is synchronous and active low; it clears valid, dirty and counters; way i gets rank i.
`timescale 1ns / 1ps

module lru_writeback_cache_set
    import lwcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [WAY_W-1:0] RANK_TOP = WAY_W'(WAYS - 1);
    localparam logic [WAY_W-1:0] IDX_LAST = WAY_W'(WAYS - 1);

    t_state r_state, n_state;
    t_ctl   ctl;

    logic [TAG_BITS-1:0] r_tag   [WAYS];
    logic [WAYS-1:0]     r_valid;
    logic [WAYS-1:0]     r_dirty;
    logic [WAY_W-1:0]    r_rank  [WAYS];

    logic [CNT_W-1:0] r_hits, r_misses, r_wbs;

    logic                r_action;
    logic [TAG_BITS-1:0] r_key;
    logic [WAY_W-1:0]    r_idx;
    logic                r_found;
    logic [WAY_W-1:0]    r_hit_way;
    logic [WAY_W-1:0]    r_best;
    logic [WAY_W-1:0]    r_best_rank;

    logic      r_out_valid;
    t_out_item r_out_item;

    logic             in_accept;
    logic             cur_match;
    logic             first;
    logic             n_found;
    logic [WAY_W-1:0] n_hit_way;
    logic [WAY_W-1:0] n_best;
    logic [WAY_W-1:0] n_best_rank;
    logic [WAY_W-1:0] upd_way;
    logic [WAY_W-1:0] old_rank;
    logic             upd_wb;
    logic [WAYS-1:0]  rank_seen;

    assign in_accept   = i_in_valid && !ctl.in_stall;
    assign o_in_stall  = ctl.in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == IDX_LAST) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (ctl.upd_en) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        case (r_state)
            S_IDLE: begin
                ctl.in_stall = 1'b0;
            end
            S_SCAN: begin
                ctl.in_stall = 1'b1;
                ctl.scan_en  = 1'b1;
            end
            S_UPDATE: begin
                ctl.in_stall = 1'b1;
                ctl.upd_en   = !r_out_valid || !i_out_stall;
            end
            default: ctl.in_stall = 1'b1;
        endcase
    end

    // The single comparator looks at one way per cycle.
    always_comb begin
        first       = (r_idx == '0);
        cur_match   = r_valid[r_idx] && (r_tag[r_idx] == r_key);
        n_found     = first ? cur_match : (r_found || cur_match);
        n_hit_way   = r_hit_way;
        n_best      = r_best;
        n_best_rank = r_best_rank;
        if (cur_match && (first || !r_found)) begin
            n_hit_way = r_idx;
        end
        if (first || (r_rank[r_idx] < r_best_rank)) begin
            n_best      = r_idx;
            n_best_rank = r_rank[r_idx];
        end
    end

    always_comb begin
        upd_way  = r_found ? r_hit_way : r_best;
        old_rank = r_rank[upd_way];
        upd_wb   = !r_found && r_valid[upd_way] && r_dirty[upd_way];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action <= i_in_item.action;
            r_key    <= TAG_BITS'(i_in_item.tag);
        end
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (in_accept) begin
            r_idx <= '0;
        end else if (ctl.scan_en) begin
            r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + WAY_W'(1);
        end
        if (ctl.scan_en) begin
            r_found     <= n_found;
            r_hit_way   <= n_hit_way;
            r_best      <= n_best;
            r_best_rank <= n_best_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.upd_en && !r_found) begin
            r_tag[upd_way] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_wbs    <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_rank[i] <= WAY_W'(i);
            end
        end else if (ctl.upd_en) begin
            if (r_found) begin
                r_hits <= sat_inc(r_hits);
                if (r_action == ACT_WRITE) begin
                    r_dirty[upd_way] <= 1'b1;
                end
            end else begin
                r_misses         <= sat_inc(r_misses);
                r_valid[upd_way] <= 1'b1;
                r_dirty[upd_way] <= (r_action == ACT_WRITE);
                if (upd_wb) begin
                    r_wbs <= sat_inc(r_wbs);
                end
            end
            for (int i = 0; i < WAYS; i++) begin
                if (WAY_W'(i) == upd_way) begin
                    r_rank[i] <= RANK_TOP;
                end else if (r_rank[i] > old_rank) begin
                    r_rank[i] <= r_rank[i] - WAY_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.upd_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (ctl.upd_en) begin
            r_out_item.hit             <= r_found;
            r_out_item.way             <= WAY_FIELD_W'(upd_way);
            r_out_item.writeback       <= upd_wb;
            r_out_item.victim_tag      <= upd_wb ? TAG_FIELD_W'(r_tag[upd_way]) : '0;
            r_out_item.hit_count       <= r_found ? sat_inc(r_hits) : r_hits;
            r_out_item.miss_count      <= r_found ? r_misses : sat_inc(r_misses);
            r_out_item.writeback_count <= upd_wb ? sat_inc(r_wbs) : r_wbs;
        end
    end

    always_comb begin
        rank_seen = '0;
        for (int i = 0; i < WAYS; i++) begin
            rank_seen[r_rank[i]] = 1'b1;
        end
    end

`include "lru_writeback_cache_set_assert.svh"

    `LWCS_ASSERT_SAME(a_rank_perm, i_clk, i_rst_n, 1'b1, &rank_seen, "recency ranks are not a permutation")
    `LWCS_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, in_accept, (r_state == S_SCAN) && (r_idx == '0), "accepted item did not start the scan")
    `LWCS_ASSERT_SAME(a_out_wb_miss, i_clk, i_rst_n, r_out_valid && r_out_item.writeback, !r_out_item.hit, "writeback reported on a hit")
    `LWCS_ASSERT_SAME(a_out_vtag, i_clk, i_rst_n, r_out_valid && !r_out_item.writeback, r_out_item.victim_tag == '0, "victim tag set without writeback")
    `LWCS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, ctl.upd_en, r_out_valid && (r_state == S_IDLE), "update did not load the output register")

endmodule
